// ===== rtl/core/wps_pkg.sv =====
// Shared types and constants for the WAV PCM stream parser.
`default_nettype none
package wps_pkg;

    // Result kinds
    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_NOT_RIFF     = 4'd0;
    localparam logic [3:0] ERR_NOT_WAVE     = 4'd1;
    localparam logic [3:0] ERR_REPEAT_FMT   = 4'd2;
    localparam logic [3:0] ERR_FMT_SHORT    = 4'd3;
    localparam logic [3:0] ERR_NOT_PCM      = 4'd4;
    localparam logic [3:0] ERR_CHANNELS     = 4'd5;
    localparam logic [3:0] ERR_ZERO_RATE    = 4'd6;
    localparam logic [3:0] ERR_BITS         = 4'd7;
    localparam logic [3:0] ERR_ALIGN        = 4'd8;
    localparam logic [3:0] ERR_BYTE_RATE    = 4'd9;
    localparam logic [3:0] ERR_DATA_NO_FMT  = 4'd10;
    localparam logic [3:0] ERR_SIZE_MULT    = 4'd11;
    localparam logic [3:0] ERR_SIZE_ZERO    = 4'd12;

    // Chunk tags, little-endian
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN = 32'd16;

    // Queue between parser and output stage
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] left_sample;
        logic [15:0] right_sample;
        logic        last_sample;
        logic [1:0]  channel_count;
        logic [4:0]  bits_per_channel;
        logic [31:0] sample_rate;
        logic [31:0] frame_count;
        logic [3:0]  error_code;
    } wps_result_t;

endpackage
`default_nettype wire

// ===== rtl/core/wps_front.sv =====
// Byte parser: walks the RIFF/WAVE container and builds result words.
`default_nettype none
module wps_front
    import wps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_take,
    input  wire logic [7:0]  data_byte,
    input  wire logic        restart,
    output logic             res_push,
    output wps_result_t      res_word
);

    typedef enum logic [3:0] {
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE, PH_FTAG, PH_FCH,
        PH_FRATE, PH_FBRATE, PH_FALIGN, PH_FBITS, PH_SKIP, PH_DATA, PH_IDLE
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [1:0]  idx_reg, idx_next, idx_cur;
    logic [31:0] shift_reg, shift_next, shift_cur;
    logic [31:0] tag_reg, tag_next, tag_cur;
    logic [31:0] clen_reg, clen_next, clen_cur;
    logic [31:0] skip_reg, skip_next, skip_cur;
    logic [1:0]  ch_reg, ch_next, ch_cur;
    logic [4:0]  bits_reg, bits_next, bits_cur;
    logic [31:0] rate_reg, rate_next, rate_cur;
    logic [31:0] brate_reg, brate_next, brate_cur;
    logic [15:0] align_reg, align_next, align_cur;
    logic [31:0] frames_reg, frames_next, frames_cur;

    logic [3:0]  field_len;
    logic [31:0] field_val;
    logic        field_done;
    logic [6:0]  prod_cur, prod_new;
    logic [3:0]  div_cur, div_new;
    logic [34:0] brate_expect;
    logic [31:0] frames_dec;
    logic [15:0] left_s, right_s;

    // Restart byte sees the reset state
    always_comb
    begin
        if (restart)
        begin
            phase_cur  = PH_RIFF;
            idx_cur    = '0;
            shift_cur  = '0;
            tag_cur    = '0;
            clen_cur   = '0;
            skip_cur   = '0;
            ch_cur     = '0;
            bits_cur   = '0;
            rate_cur   = '0;
            brate_cur  = '0;
            align_cur  = '0;
            frames_cur = '0;
        end
        else
        begin
            phase_cur  = phase_reg;
            idx_cur    = idx_reg;
            shift_cur  = shift_reg;
            tag_cur    = tag_reg;
            clen_cur   = clen_reg;
            skip_cur   = skip_reg;
            ch_cur     = ch_reg;
            bits_cur   = bits_reg;
            rate_cur   = rate_reg;
            brate_cur  = brate_reg;
            align_cur  = align_reg;
            frames_cur = frames_reg;
        end
    end

    // Bytes per frame
    assign prod_cur = 7'(ch_cur) * 7'(bits_cur);
    assign div_cur  = prod_cur[6:3];

    // Field length per phase
    always_comb
    begin
        unique case (phase_cur)
            PH_FTAG, PH_FCH, PH_FALIGN, PH_FBITS: field_len = 4'd2;
            PH_DATA:                               field_len = div_cur;
            default:                               field_len = 4'd4;
        endcase
    end

    // Little-endian field assembly
    always_comb
    begin
        unique case (idx_cur)
            2'd0:    field_val = shift_cur | {24'd0, data_byte};
            2'd1:    field_val = shift_cur | {16'd0, data_byte, 8'd0};
            2'd2:    field_val = shift_cur | {8'd0, data_byte, 16'd0};
            default: field_val = shift_cur | {data_byte, 24'd0};
        endcase
    end
    assign field_done = ({2'b00, idx_cur} + 4'd1) >= field_len;

    assign prod_new = 7'(ch_cur) * 7'(field_val[4:0]);
    assign div_new  = prod_new[6:3];

    always_comb
    begin
        unique case (div_new)
            4'd2:    brate_expect = {2'b00, rate_cur, 1'b0};
            4'd4:    brate_expect = {1'b0, rate_cur, 2'b00};
            default: brate_expect = {3'b000, rate_cur};
        endcase
    end

    assign frames_dec = (frames_cur != '0) ? frames_cur - 32'd1 : frames_cur;

    // Sample split
    always_comb
    begin
        if (bits_cur == 5'd8)
        begin
            left_s  = {8'd0, field_val[7:0]};
            right_s = {8'd0, field_val[15:8]};
        end
        else
        begin
            left_s  = field_val[15:0];
            right_s = field_val[31:16];
        end
        if (ch_cur == 2'd1)
            right_s = left_s;
    end

    // Phase logic
    always_comb
    begin
        phase_next  = phase_cur;
        idx_next    = idx_cur;
        shift_next  = shift_cur;
        tag_next    = tag_cur;
        clen_next   = clen_cur;
        skip_next   = skip_cur;
        ch_next     = ch_cur;
        bits_next   = bits_cur;
        rate_next   = rate_cur;
        brate_next  = brate_cur;
        align_next  = align_cur;
        frames_next = frames_cur;
        res_push    = 1'b0;
        res_word    = '0;

        if (phase_cur != PH_SKIP && phase_cur != PH_IDLE)
        begin
            if (field_done)
            begin
                idx_next   = '0;
                shift_next = '0;
            end
            else
            begin
                idx_next   = idx_cur + 2'd1;
                shift_next = field_val;
            end
        end

        unique case (phase_cur)
            PH_RIFF:
                if (field_done)
                begin
                    if (field_val != TAG_RIFF)
                    begin
                        phase_next = PH_IDLE;
                        res_push = 1'b1;
                        res_word.kind = KIND_ERROR;
                        res_word.error_code = ERR_NOT_RIFF;
                    end
                    else
                        phase_next = PH_RSIZE;
                end
            PH_RSIZE:
                if (field_done)
                    phase_next = PH_WAVE;
            PH_WAVE:
                if (field_done)
                begin
                    if (field_val != TAG_WAVE)
                    begin
                        phase_next = PH_IDLE;
                        res_push = 1'b1;
                        res_word.kind = KIND_ERROR;
                        res_word.error_code = ERR_NOT_WAVE;
                    end
                    else
                        phase_next = PH_CID;
                end
            PH_CID:
                if (field_done)
                begin
                    tag_next   = field_val;
                    phase_next = PH_CSIZE;
                end
            PH_CSIZE:
                if (field_done)
                begin
                    clen_next = field_val;
                    if (tag_cur == TAG_FMT)
                    begin
                        if (ch_cur != '0 || field_val < FMT_MIN)
                        begin
                            phase_next = PH_IDLE;
                            res_push = 1'b1;
                            res_word.kind = KIND_ERROR;
                            res_word.error_code =
                                (ch_cur != '0) ? ERR_REPEAT_FMT : ERR_FMT_SHORT;
                        end
                        else
                            phase_next = PH_FTAG;
                    end
                    else if (tag_cur == TAG_DATA)
                    begin
                        res_push = 1'b1;
                        if (div_cur == '0)
                        begin
                            phase_next = PH_IDLE;
                            res_word.kind = KIND_ERROR;
                            res_word.error_code = ERR_DATA_NO_FMT;
                        end
                        else if ((div_cur == 4'd2 && field_val[0]) ||
                                 (div_cur == 4'd4 && field_val[1:0] != 2'b00))
                        begin
                            phase_next = PH_IDLE;
                            res_word.kind = KIND_ERROR;
                            res_word.error_code = ERR_SIZE_MULT;
                        end
                        else if (field_val == '0)
                        begin
                            phase_next = PH_IDLE;
                            res_word.kind = KIND_ERROR;
                            res_word.error_code = ERR_SIZE_ZERO;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                            if (div_cur == 4'd4)
                                frames_next = {2'b00, field_val[31:2]};
                            else if (div_cur == 4'd2)
                                frames_next = {1'b0, field_val[31:1]};
                            else
                                frames_next = field_val;
                            res_word.kind = KIND_FORMAT;
                            res_word.channel_count = ch_cur;
                            res_word.bits_per_channel = bits_cur;
                            res_word.sample_rate = rate_cur;
                            res_word.frame_count = frames_next;
                        end
                    end
                    else if (field_val != '0)
                    begin
                        skip_next  = field_val;
                        phase_next = PH_SKIP;
                    end
                    else
                        phase_next = PH_CID;
                end
            PH_FTAG:
                if (field_done)
                begin
                    if (field_val != 32'd1)
                    begin
                        phase_next = PH_IDLE;
                        res_push = 1'b1;
                        res_word.kind = KIND_ERROR;
                        res_word.error_code = ERR_NOT_PCM;
                    end
                    else
                        phase_next = PH_FCH;
                end
            PH_FCH:
                if (field_done)
                begin
                    if (field_val != 32'd1 && field_val != 32'd2)
                    begin
                        phase_next = PH_IDLE;
                        res_push = 1'b1;
                        res_word.kind = KIND_ERROR;
                        res_word.error_code = ERR_CHANNELS;
                    end
                    else
                    begin
                        ch_next    = field_val[1:0];
                        phase_next = PH_FRATE;
                    end
                end
            PH_FRATE:
                if (field_done)
                begin
                    rate_next = field_val;
                    if (field_val == '0)
                    begin
                        phase_next = PH_IDLE;
                        res_push = 1'b1;
                        res_word.kind = KIND_ERROR;
                        res_word.error_code = ERR_ZERO_RATE;
                    end
                    else
                        phase_next = PH_FBRATE;
                end
            PH_FBRATE:
                if (field_done)
                begin
                    brate_next = field_val;
                    phase_next = PH_FALIGN;
                end
            PH_FALIGN:
                if (field_done)
                begin
                    align_next = field_val[15:0];
                    phase_next = PH_FBITS;
                end
            PH_FBITS:
                if (field_done)
                begin
                    if (field_val != 32'd8 && field_val != 32'd16)
                    begin
                        phase_next = PH_IDLE;
                        res_push = 1'b1;
                        res_word.kind = KIND_ERROR;
                        res_word.error_code = ERR_BITS;
                    end
                    else
                    begin
                        bits_next = field_val[4:0];
                        if (align_cur != {12'd0, div_new})
                        begin
                            phase_next = PH_IDLE;
                            res_push = 1'b1;
                            res_word.kind = KIND_ERROR;
                            res_word.error_code = ERR_ALIGN;
                        end
                        else if (brate_expect != {3'b000, brate_cur})
                        begin
                            phase_next = PH_IDLE;
                            res_push = 1'b1;
                            res_word.kind = KIND_ERROR;
                            res_word.error_code = ERR_BYTE_RATE;
                        end
                        else if (clen_cur > FMT_MIN)
                        begin
                            skip_next  = clen_cur - FMT_MIN;
                            phase_next = PH_SKIP;
                        end
                        else
                            phase_next = PH_CID;
                    end
                end
            PH_SKIP:
            begin
                skip_next = (skip_cur != '0) ? skip_cur - 32'd1 : skip_cur;
                if (skip_next == '0)
                    phase_next = PH_CID;
            end
            PH_DATA:
                if (field_done)
                begin
                    frames_next = frames_dec;
                    if (frames_dec == '0)
                        phase_next = PH_IDLE;
                    res_push = 1'b1;
                    res_word.kind = KIND_SAMPLE;
                    res_word.left_sample = left_s;
                    res_word.right_sample = right_s;
                    res_word.last_sample = (frames_dec == '0);
                end
            PH_IDLE: ;
            default: ;
        endcase

        if (!byte_take)
            res_push = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RIFF;
            idx_reg    <= '0;
            shift_reg  <= '0;
            tag_reg    <= '0;
            clen_reg   <= '0;
            skip_reg   <= '0;
            ch_reg     <= '0;
            bits_reg   <= '0;
            rate_reg   <= '0;
            brate_reg  <= '0;
            align_reg  <= '0;
            frames_reg <= '0;
        end
        else if (byte_take)
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            shift_reg  <= shift_next;
            tag_reg    <= tag_next;
            clen_reg   <= clen_next;
            skip_reg   <= skip_next;
            ch_reg     <= ch_next;
            bits_reg   <= bits_next;
            rate_reg   <= rate_next;
            brate_reg  <= brate_next;
            align_reg  <= align_next;
            frames_reg <= frames_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/wps_fifo.sv =====
// Short result queue between parser and output stage.
`default_nettype none
module wps_fifo
    import wps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wps_result_t      push_word,
    output logic             has_room,
    input  wire logic        pop,
    output logic             not_empty,
    output wps_result_t      head_word
);

    wps_result_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]       count_reg;

    assign has_room  = count_reg != QCNT_W'(QDEPTH);
    assign not_empty = count_reg != '0;
    assign head_word = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/wps_back.sv =====
// Output stage: pulls result words from the queue into the port register.
`default_nettype none
module wps_back
    import wps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_not_empty,
    input  wps_result_t      q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output wps_result_t      out_word
);

    logic        valid_reg;
    wps_result_t word_reg;

    assign q_pop     = q_not_empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || out_ready)
            valid_reg <= q_not_empty;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            word_reg <= q_head;
    end

endmodule
`default_nettype wire

// ===== rtl/core/wav_pcm_stream_parser.sv =====
// Top level of the WAV PCM stream parser.
//
//  Channel | Handshake            | Word
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_ready  | data_byte, restart
//  output  | out_valid/ out_ready | kind, samples, last, format fields, error
//
//  One byte is taken per cycle while in_ready is high; the parser decides each
//  byte in the cycle it is taken. A result is written to the result queue and
//  then moved into the output register. in_ready drops only when the two-entry result queue is full.
//  Reset clears the parser to expect a RIFF tag and empties queue and output.
`default_nettype none
module wav_pcm_stream_parser
    import wps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [15:0]      left_sample,
    output logic [15:0]      right_sample,
    output logic             last_sample,
    output logic [1:0]       channel_count,
    output logic [4:0]       bits_per_channel,
    output logic [31:0]      sample_rate,
    output logic [31:0]      frame_count,
    output logic [3:0]       error_code
);

    logic        byte_take;
    logic        res_push;
    wps_result_t res_word;
    logic        q_room, q_not_empty, q_pop;
    wps_result_t q_head, out_word;

    assign in_ready  = q_room;
    assign byte_take = in_valid && q_room;

    wps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_take (byte_take),
        .data_byte (data_byte),
        .restart   (restart),
        .res_push  (res_push),
        .res_word  (res_word)
    );

    wps_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_word (res_word),
        .has_room  (q_room),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_word (q_head)
    );

    wps_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word)
    );

    assign kind             = out_word.kind;
    assign left_sample      = out_word.left_sample;
    assign right_sample     = out_word.right_sample;
    assign last_sample      = out_word.last_sample;
    assign channel_count    = out_word.channel_count;
    assign bits_per_channel = out_word.bits_per_channel;
    assign sample_rate      = out_word.sample_rate;
    assign frame_count      = out_word.frame_count;
    assign error_code       = out_word.error_code;

endmodule
`default_nettype wire
